// File: rtl/texture_page_clut_fetch_assert.svh
// assertion macros shared by the rtl of the texture page color table fetch block
// depends on nothing; the assertions compile away when SYNTHESIS is defined
`ifndef TEXTURE_PAGE_CLUT_FETCH_ASSERT_SVH
`define TEXTURE_PAGE_CLUT_FETCH_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define TPCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define TPCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPCF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPCF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/tpcf_pkg.sv
// shared types and constants of the texture page color table fetch block
// no dependencies
package tpcf_pkg;

    localparam int WORD_W      = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 1;

    // transaction kind carried in tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_PAGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUT_WORD = 1'b1;

    // texel depth codes from texture page bits 7-8
    localparam logic [1:0] DEPTH_4  = 2'd0;
    localparam logic [1:0] DEPTH_8  = 2'd1;

    localparam logic [WORD_W-1:0] NIBBLE_MASK = 16'h000F;
    localparam logic [WORD_W-1:0] BYTE_MASK   = 16'h00FF;

    // input payload, last field in the lowest bits
    typedef struct packed {
        logic [7:0]        tex_v;
        logic [7:0]        tex_u;
        logic [WORD_W-1:0] write_word;
        logic [8:0]        mem_row;
        logic [8:0]        mem_col;
    } t_in_item;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0] colour_index;
        logic [7:0]        alpha;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
    } t_texel;

endpackage

// File: rtl/tpcf_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tpcf_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/texture_page_clut_fetch.sv
// texture page and color table lookup over a MEM_WIDTH x MEM_HEIGHT video memory.
// A write transaction (tuser = 0) stores one 16-bit word at (mem_col, mem_row); writes outside
// the store are dropped. A fetch transaction (tuser = 1) reads the texture word at (tex_u,
// tex_v) inside the page that texture_page selects, takes a 4, 8 or 16 bit color index from
// it, reads the color table word at clut_word offset by that index and returns it expanded
// to 8-bit rgb plus an alpha of 255 for a nonzero word. Rows past the store read as zero.
// Rate: one item at a time. A write is accepted, then written to memory. A fetch steps through
// texture address, texture read, index, remainder, table address, table read and output
// steps before its result is valid: the two reads go one after the other through the single
// read port of the video memory, and the color table column is reduced modulo MEM_WIDTH by a
// reciprocal multiply and a correction. A finished result waits in the output register while
// the next transaction is accepted; a fetch that finds the output register still full waits
// in its last step. The memory is not cleared after reset; an entry must be written before
// it is read. Configuration must be written only when idle; the block does not enforce it.
// depends on tpcf_pkg, tpcf_ram and texture_page_clut_fetch_assert.svh
`include "texture_page_clut_fetch_assert.svh"

module texture_page_clut_fetch #(
    parameter int MEM_WIDTH  = 512,
    parameter int MEM_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tpcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpcf_pkg::WORD_W-1:0]         i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mem_col, mem_row, write_word, tex_u, tex_v, zero padding
    input  logic [tpcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red, green, blue, alpha, colour_index
    output logic [tpcf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CW        = $clog2(MEM_WIDTH);
    localparam int AW        = $clog2(MEM_WIDTH * MEM_HEIGHT);
    localparam int COL_STEPS = 256 / MEM_WIDTH + 1;
    // reciprocal for index / MEM_WIDTH, exact to within one for 16-bit indexes
    localparam int RECIP     = 65536 / MEM_WIDTH;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PW        = 16 + RECIP_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WRITE = 4'd1;
    localparam logic [3:0] ST_TCOL  = 4'd2;
    localparam logic [3:0] ST_TREAD = 4'd3;
    localparam logic [3:0] ST_TWAIT = 4'd4;
    localparam logic [3:0] ST_CMOD  = 4'd5;
    localparam logic [3:0] ST_CCOL  = 4'd6;
    localparam logic [3:0] ST_CREAD = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    typedef logic [CW-1:0] t_px_tab [32];
    typedef logic [CW-1:0] t_cb_tab [64];

    // page x origin modulo the store width, one entry per page column code
    function automatic t_px_tab make_px_tab();
        t_px_tab tab;
        for (int k = 0; k < 32; k++) begin
            tab[k] = CW'((k * 64) % MEM_WIDTH);
        end
        return tab;
    endfunction

    // color table base column modulo the store width
    function automatic t_cb_tab make_cb_tab();
        t_cb_tab tab;
        for (int k = 0; k < 64; k++) begin
            tab[k] = CW'((k * 16) % MEM_WIDTH);
        end
        return tab;
    endfunction

    localparam t_px_tab PX_TAB = make_px_tab();
    localparam t_cb_tab CB_TAB = make_cb_tab();

    function automatic logic [AW-1:0] addr_of(input logic [9:0] row, input logic [CW-1:0] col);
        return AW'(AW'(row) * AW'(MEM_WIDTH) + AW'(col));
    endfunction

    logic [3:0]                  r_state;
    logic [3:0]                  n_state;
    logic [tpcf_pkg::WORD_W-1:0] r_tex_page;
    logic [tpcf_pkg::WORD_W-1:0] r_clut_word;
    tpcf_pkg::t_in_item          r_item;
    logic [CW-1:0]               r_tcol;
    logic [9:0]                  r_trow;
    logic                        r_tzero;
    logic [tpcf_pkg::WORD_W-1:0] r_idx;
    logic [PW-1:0]               r_prod;
    logic [CW:0]                 r_rem;
    logic [CW-1:0]               r_ccol;
    logic                        r_czero;
    tpcf_pkg::t_texel            r_out;
    logic                        r_out_valid;

    logic                        w_in_acc;
    logic [1:0]                  w_depth;
    logic [7:0]                  w_uoff;
    logic [10:0]                 w_tsum;
    logic [9:0]                  w_trow;
    logic [tpcf_pkg::WORD_W-1:0] w_word;
    logic [tpcf_pkg::WORD_W-1:0] w_idx;
    logic [RECIP_W-1:0]          w_q;
    logic [16:0]                 w_qw;
    logic [16:0]                 w_rem_full;
    logic [CW:0]                 w_rem1;
    logic [CW:0]                 w_csum;
    logic [CW-1:0]               w_ccol;
    logic [tpcf_pkg::WORD_W-1:0] w_colour;
    logic                        w_out_free;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic [tpcf_pkg::WORD_W-1:0] w_rdata;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_depth       = r_tex_page[8:7];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_page  <= '0;
            r_clut_word <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpcf_pkg::CFG_TEX_PAGE:  r_tex_page  <= i_cfg_data;
                tpcf_pkg::CFG_CLUT_WORD: r_clut_word <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (s_axis_tuser == tpcf_pkg::FUNC_WRITE) ? ST_WRITE : ST_TCOL;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_TCOL:  n_state = ST_TREAD;
            ST_TREAD: n_state = ST_TWAIT;
            ST_TWAIT: n_state = ST_CMOD;
            ST_CMOD:  n_state = ST_CCOL;
            ST_CCOL:  n_state = ST_CREAD;
            ST_CREAD: n_state = ST_OUT;
            ST_OUT: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // texel column within the page, wrapped to the store width
    always_comb begin
        case (w_depth)
            tpcf_pkg::DEPTH_4: w_uoff = {2'b00, r_item.tex_u[7:2]};
            tpcf_pkg::DEPTH_8: w_uoff = {1'b0, r_item.tex_u[7:1]};
            default:           w_uoff = r_item.tex_u;
        endcase
        w_tsum = 11'(PX_TAB[r_tex_page[4:0]]) + 11'(w_uoff);
        for (int s = 0; s < COL_STEPS; s++) begin
            if (w_tsum >= 11'(MEM_WIDTH)) begin
                w_tsum = w_tsum - 11'(MEM_WIDTH);
            end
        end
    end

    // page y: bit 4 adds 256, bit 11 adds 512
    assign w_trow = {r_tex_page[11], r_tex_page[4], 8'h00} + 10'(r_item.tex_v);

    // color index out of the texture word
    always_comb begin
        w_word = r_tzero ? '0 : w_rdata;
        case (w_depth)
            tpcf_pkg::DEPTH_4:
                w_idx = (w_word >> {r_item.tex_u[1:0], 2'b00}) & tpcf_pkg::NIBBLE_MASK;
            tpcf_pkg::DEPTH_8:
                w_idx = (w_word >> {r_item.tex_u[0], 3'b000}) & tpcf_pkg::BYTE_MASK;
            default:
                w_idx = w_word;
        endcase
    end

    // index modulo the store width: quotient estimate low by at most one
    assign w_q        = r_prod[PW-1:16];
    assign w_qw       = 17'(w_q) * 17'(MEM_WIDTH);
    assign w_rem_full = {1'b0, r_idx} - w_qw;

    always_comb begin
        w_rem1 = (r_rem >= (CW+1)'(MEM_WIDTH)) ? r_rem - (CW+1)'(MEM_WIDTH) : r_rem;
        w_csum = (CW+1)'(CB_TAB[r_clut_word[5:0]]) + w_rem1;
        w_ccol = (w_csum >= (CW+1)'(MEM_WIDTH)) ? CW'(w_csum - (CW+1)'(MEM_WIDTH))
                                                 : CW'(w_csum);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= tpcf_pkg::t_in_item'(s_axis_tdata[$bits(tpcf_pkg::t_in_item)-1:0]);
        end
        if (r_state == ST_TCOL) begin
            r_tcol  <= CW'(w_tsum);
            r_trow  <= w_trow;
            r_tzero <= (w_trow >= 10'(MEM_HEIGHT - 1)) && (w_trow != 10'(MEM_HEIGHT - 1));
        end
        if (r_state == ST_TWAIT) begin
            r_idx  <= w_idx;
            r_prod <= PW'(w_idx) * PW'(RECIP);
        end
        if (r_state == ST_CMOD) begin
            r_rem <= (CW+1)'(w_rem_full);
        end
        if (r_state == ST_CCOL) begin
            r_ccol  <= w_ccol;
            r_czero <= (11'(r_clut_word[15:6]) >= 11'(MEM_HEIGHT));
        end
    end

    // video memory access
    assign w_we    = (r_state == ST_WRITE)
                  && (11'(r_item.mem_col) < 11'(MEM_WIDTH))
                  && (11'(r_item.mem_row) < 11'(MEM_HEIGHT));
    assign w_waddr = addr_of({1'b0, r_item.mem_row}, CW'(r_item.mem_col));
    assign w_re    = ((r_state == ST_TREAD) && !r_tzero) || ((r_state == ST_CREAD) && !r_czero);
    assign w_raddr = (r_state == ST_TREAD) ? addr_of(r_trow, r_tcol)
                                           : addr_of(r_clut_word[15:6], r_ccol);

    tpcf_ram #(
        .WIDTH (tpcf_pkg::WORD_W),
        .DEPTH (MEM_WIDTH * MEM_HEIGHT)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_item.write_word),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // 5-5-5 expansion into the output register
    assign w_colour = r_czero ? '0 : w_rdata;

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out.red          <= {w_colour[4:0], 3'b000};
            r_out.green        <= {w_colour[9:5], 3'b000};
            r_out.blue         <= {w_colour[14:10], 3'b000};
            r_out.alpha        <= (w_colour != '0) ? 8'hFF : 8'h00;
            r_out.colour_index <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `TPCF_ASSERT(a_write_seq, i_clk, i_rst_n,
        (w_in_acc && s_axis_tuser == tpcf_pkg::FUNC_WRITE) |=> (r_state == ST_WRITE),
        "write transaction did not reach the memory write step")
    `TPCF_ASSERT(a_tcol_range, i_clk, i_rst_n,
        (r_state == ST_TREAD) |-> (r_tcol < MEM_WIDTH), "texture column not wrapped")
    `TPCF_ASSERT(a_rem_range, i_clk, i_rst_n,
        (r_state == ST_CCOL) |-> (r_rem < 2 * MEM_WIDTH),
        "index remainder out of correction range")
    `TPCF_ASSERT(a_out_source, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT),
        "result appeared outside the output step")
    `TPCF_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

// File: tb/texture_page_clut_fetch_checker.sv
// checker for the texture page color table fetch block: watches config writes and both streams
// keeps its own copy of video memory and registers, predicts each texel and compares in order
// depends on tpcf_pkg
module texture_page_clut_fetch_checker #(
    parameter int MEM_WIDTH  = 512,
    parameter int MEM_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tpcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpcf_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // mem_col, mem_row, write_word, tex_u, tex_v, zero padding
    input  logic [tpcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red, green, blue, alpha, colour_index
    input  logic [tpcf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bit   [tpcf_pkg::WORD_W-1:0] vram_copy [MEM_WIDTH*MEM_HEIGHT];
    logic [tpcf_pkg::WORD_W-1:0] tex_page;
    logic [tpcf_pkg::WORD_W-1:0] clut_loc;
    tpcf_pkg::t_texel            pending_texels [$];

    // rows past the store read as zero
    function automatic logic [tpcf_pkg::WORD_W-1:0] vram_word(input int col, input int row);
        if (row >= MEM_HEIGHT) return '0;
        return vram_copy[row*MEM_WIDTH + col];
    endfunction

    function automatic tpcf_pkg::t_texel lookup_texel(input logic [7:0] u, input logic [7:0] v);
        int                          page_x;
        int                          page_y;
        int                          row;
        int                          idx;
        int                          clut_col;
        int                          clut_row;
        logic [tpcf_pkg::WORD_W-1:0] word;
        logic [tpcf_pkg::WORD_W-1:0] colour;
        tpcf_pkg::t_texel            texel;
        page_x = ((int'(tex_page) << 6) & 'h7C0) % MEM_WIDTH;
        page_y = ((int'(tex_page) << 4) & 'h100) + ((int'(tex_page) >> 2) & 'h200);
        row    = page_y + int'(v);
        case (tex_page[8:7])
            tpcf_pkg::DEPTH_4: begin
                word = vram_word((page_x + int'(u >> 2)) % MEM_WIDTH, row);
                idx  = int'((word >> (u[1:0] * 4)) & tpcf_pkg::NIBBLE_MASK);
            end
            tpcf_pkg::DEPTH_8: begin
                word = vram_word((page_x + int'(u >> 1)) % MEM_WIDTH, row);
                idx  = int'((word >> (u[0] * 8)) & tpcf_pkg::BYTE_MASK);
            end
            // 16 bit, and depth three behaves the same
            default: begin
                word = vram_word((page_x + int'(u)) % MEM_WIDTH, row);
                idx  = int'(word);
            end
        endcase
        clut_col = ((((int'(clut_loc) & 'h3F) << 4) % MEM_WIDTH) + idx) % MEM_WIDTH;
        clut_row = int'(clut_loc) >> 6;
        colour   = vram_word(clut_col, clut_row);
        texel.red          = {colour[4:0], 3'b000};
        texel.green        = {colour[9:5], 3'b000};
        texel.blue         = {colour[14:10], 3'b000};
        texel.alpha        = (colour != '0) ? 8'hFF : 8'h00;
        texel.colour_index = tpcf_pkg::WORD_W'(idx);
        return texel;
    endfunction

    task automatic note_failure(input string what, input tpcf_pkg::t_texel want,
                                input tpcf_pkg::t_texel got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("    expected r=%h g=%h b=%h a=%h idx=%h", want.red, want.green,
                     want.blue, want.alpha, want.colour_index);
            $display("    actual   r=%h g=%h b=%h a=%h idx=%h", got.red, got.green,
                     got.blue, got.alpha, got.colour_index);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        tpcf_pkg::t_in_item item;
        tpcf_pkg::t_texel   got;
        tpcf_pkg::t_texel   want;
        if (!i_rst_n) begin
            tex_page = '0;
            clut_loc = '0;
            pending_texels.delete();
        end else begin
            // results first: a result never belongs to a fetch taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = tpcf_pkg::t_texel'(m_axis_tdata);
                if (pending_texels.size() == 0) begin
                    note_failure("texel with no fetch waiting", '0, got);
                end else begin
                    want = pending_texels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.colour_index !== want.colour_index)
                        note_failure("texel mismatch", want, got);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpcf_pkg::CFG_TEX_PAGE:  tex_page = i_cfg_data;
                    tpcf_pkg::CFG_CLUT_WORD: clut_loc = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                item = tpcf_pkg::t_in_item'(s_axis_tdata[$bits(tpcf_pkg::t_in_item)-1:0]);
                if (s_axis_tuser == tpcf_pkg::FUNC_WRITE) begin
                    if (int'(item.mem_col) < MEM_WIDTH && int'(item.mem_row) < MEM_HEIGHT)
                        vram_copy[int'(item.mem_row)*MEM_WIDTH + int'(item.mem_col)] =
                            item.write_word;
                end else begin
                    pending_texels.insert(pending_texels.size(),
                                          lookup_texel(item.tex_u, item.tex_v));
                end
            end
        end
        o_pending = pending_texels.size();
    end

endmodule

// File: tb/tb_texture_page_clut_fetch.sv
// testbench top for the texture page color table fetch block: clock, reset, stimulus, verdict
// every fetch is made legal by first writing any texture or table word it would read unwritten
// depends on tpcf_pkg, texture_page_clut_fetch and texture_page_clut_fetch_checker
module tb_texture_page_clut_fetch;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WIDTH      = 512;
    localparam int MEM_HEIGHT     = 512;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [tpcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx     = tpcf_pkg::CFG_TEX_PAGE;
    logic [tpcf_pkg::WORD_W-1:0]        i_cfg_data    = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic                               s_axis_tuser  = tpcf_pkg::FUNC_WRITE;
    tpcf_pkg::t_in_item                 s_item        = '0;
    logic [tpcf_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [tpcf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

    int                                 fail_count;
    int                                 pending;

    // stimulus side picture of memory: which words hold what, so no fetch reads an unwritten word
    logic [tpcf_pkg::WORD_W-1:0]        written_words [int];
    logic [tpcf_pkg::WORD_W-1:0]        cur_page      = '0;
    logic [tpcf_pkg::WORD_W-1:0]        cur_clut      = '0;
    int                                 items_sent    = 0;
    bit                                 no_idle       = 1'b0;  // stretch without gaps
    bit                                 rx_hold_req   = 1'b0;  // asks for one long hold-off
    int                                 stuck_cycles  = 0;

    // input tdata: mem_col, mem_row, write_word, tex_u, tex_v from the lowest bit, zero padding
    assign s_axis_tdata = {{(tpcf_pkg::IN_TDATA_W-$bits(tpcf_pkg::t_in_item)){1'b0}}, s_item};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    texture_page_clut_fetch #(
        .MEM_WIDTH  (MEM_WIDTH),
        .MEM_HEIGHT (MEM_HEIGHT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),   // mem_col, mem_row, write_word, tex_u, tex_v
        .s_axis_tuser   (s_axis_tuser),   // func
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)    // red, green, blue, alpha, colour_index
    );

    texture_page_clut_fetch_checker #(
        .MEM_WIDTH  (MEM_WIDTH),
        .MEM_HEIGHT (MEM_HEIGHT)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // gap lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // table words: some zero (alpha 0), some with only the top bit set, rest random
    function automatic logic [tpcf_pkg::WORD_W-1:0] pick_colour();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return '0;
        if (roll < 25) return 16'h8000;
        return tpcf_pkg::WORD_W'($urandom());
    endfunction

    // fields a transaction does not use still carry random bits
    function automatic tpcf_pkg::t_in_item random_item();
        tpcf_pkg::t_in_item item;
        item.mem_col    = 9'($urandom());
        item.mem_row    = 9'($urandom());
        item.write_word = tpcf_pkg::WORD_W'($urandom());
        item.tex_u      = 8'($urandom());
        item.tex_v      = 8'($urandom());
        return item;
    endfunction

    // receiver: random stalls, and one long hold-off when asked for it
    initial begin : receiver
        int n;
        bit hold_done;
        hold_done = 1'b0;
        @(negedge i_clk);
        forever begin
            if (rx_hold_req && !hold_done) begin
                n         = RX_HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                n = pick_gap();
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // watchdog: too long with no transaction on any port ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // one input transaction after a random gap; valid stays up when the gap is zero
    task automatic send_item(input logic func, input tpcf_pkg::t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_item        <= item;
        do @(posedge i_clk); while (!s_axis_tready);
        if (func == tpcf_pkg::FUNC_WRITE)
            written_words[int'(item.mem_row)*MEM_WIDTH + int'(item.mem_col)] = item.write_word;
        items_sent++;
    endtask

    task automatic store_word(input int col, input int row,
                              input logic [tpcf_pkg::WORD_W-1:0] word);
        tpcf_pkg::t_in_item item;
        item            = random_item();
        item.mem_col    = 9'(col);
        item.mem_row    = 9'(row);
        item.write_word = word;
        send_item(tpcf_pkg::FUNC_WRITE, item);
    endtask

    // fetch one texel, first filling in any texture or table word that was never written
    task automatic fetch_texel(input logic [7:0] u, input logic [7:0] v);
        int                          page_x;
        int                          page_y;
        int                          row;
        int                          col;
        int                          idx;
        int                          clut_col;
        int                          clut_row;
        logic [tpcf_pkg::WORD_W-1:0] word;
        tpcf_pkg::t_in_item          item;
        page_x = ((int'(cur_page) << 6) & 'h7C0) % MEM_WIDTH;
        page_y = ((int'(cur_page) << 4) & 'h100) + ((int'(cur_page) >> 2) & 'h200);
        row    = page_y + int'(v);
        case (cur_page[8:7])
            tpcf_pkg::DEPTH_4: col = (page_x + int'(u >> 2)) % MEM_WIDTH;
            tpcf_pkg::DEPTH_8: col = (page_x + int'(u >> 1)) % MEM_WIDTH;
            default:           col = (page_x + int'(u)) % MEM_WIDTH;
        endcase
        word = '0;
        if (row < MEM_HEIGHT) begin
            if (!written_words.exists(row*MEM_WIDTH + col))
                store_word(col, row, tpcf_pkg::WORD_W'($urandom()));
            word = written_words[row*MEM_WIDTH + col];
        end
        case (cur_page[8:7])
            tpcf_pkg::DEPTH_4: idx = int'((word >> (u[1:0] * 4)) & tpcf_pkg::NIBBLE_MASK);
            tpcf_pkg::DEPTH_8: idx = int'((word >> (u[0] * 8)) & tpcf_pkg::BYTE_MASK);
            default:           idx = int'(word);
        endcase
        clut_col = ((((int'(cur_clut) & 'h3F) << 4) % MEM_WIDTH) + idx) % MEM_WIDTH;
        clut_row = int'(cur_clut) >> 6;
        if (clut_row < MEM_HEIGHT && !written_words.exists(clut_row*MEM_WIDTH + clut_col))
            store_word(clut_col, clut_row, pick_colour());
        item       = random_item();
        item.tex_u = u;
        item.tex_v = v;
        send_item(tpcf_pkg::FUNC_FETCH, item);
    endtask

    // sender stops and waits until every texel is back, then lets a trailing write finish
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic write_config(input logic [tpcf_pkg::WORD_W-1:0] page,
                                input logic [tpcf_pkg::WORD_W-1:0] clut);
        drain_block();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tpcf_pkg::CFG_TEX_PAGE;
        i_cfg_data <= page;
        @(negedge i_clk);
        i_cfg_idx  <= tpcf_pkg::CFG_CLUT_WORD;
        i_cfg_data <= clut;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_page = page;
        cur_clut = clut;
    endtask

    // random item: mostly legal fetches, writes aimed at the page, the table row or anywhere
    task automatic random_transaction();
        int roll;
        int page_x;
        int page_y;
        int row;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            fetch_texel(8'($urandom()), 8'($urandom()));
        end else begin
            page_x = ((int'(cur_page) << 6) & 'h7C0) % MEM_WIDTH;
            page_y = ((int'(cur_page) << 4) & 'h100) + ((int'(cur_page) >> 2) & 'h200);
            roll   = $urandom_range(0, 99);
            row    = page_y + $urandom_range(0, 255);
            if (roll < 35 && row < MEM_HEIGHT)
                store_word((page_x + $urandom_range(0, 127)) % MEM_WIDTH, row,
                           tpcf_pkg::WORD_W'($urandom()));
            else if (roll < 60 && (int'(cur_clut) >> 6) < MEM_HEIGHT)
                store_word($urandom_range(0, MEM_WIDTH - 1), int'(cur_clut) >> 6, pick_colour());
            else
                store_word($urandom_range(0, MEM_WIDTH - 1), $urandom_range(0, MEM_HEIGHT - 1),
                           tpcf_pkg::WORD_W'($urandom()));
        end
    endtask

    initial begin : stimulus
        logic [tpcf_pkg::WORD_W-1:0] page;
        logic [tpcf_pkg::WORD_W-1:0] clut;
        int                          phase_start;
        bit                          paused;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 4 bit depth, page and table at the origin; the four nibbles of one word
        // pick table words that are zero, white, top bit only and pure red
        write_config(16'h0000, 16'h0000);
        store_word(0, 0, 16'hFEDC);
        store_word(12, 0, 16'h0000);
        store_word(13, 0, 16'h7FFF);
        store_word(14, 0, 16'h8000);
        store_word(15, 0, 16'h001F);
        fetch_texel(8'd0, 8'd0);
        fetch_texel(8'd1, 8'd0);
        fetch_texel(8'd2, 8'd0);
        fetch_texel(8'd3, 8'd0);
        store_word(MEM_WIDTH - 1, MEM_HEIGHT - 1, 16'hFFFF);
        fetch_texel(8'd255, 8'd255);

        // 8 bit depth, page x code at its top, page y bit 4 set, table column wraps past the edge
        write_config(16'h009F, 16'h003F);
        fetch_texel(8'd0, 8'd0);
        fetch_texel(8'd255, 8'd255);

        // 16 bit depth, table at the last row, full-word index wraps the column
        write_config(16'h0100, 16'h7FFF);
        store_word(5, 0, 16'hFFFF);
        fetch_texel(8'd5, 8'd0);

        // depth three; texture rows and table row both past the store read as zero
        write_config(16'hFFFF, 16'hFFFF);
        fetch_texel(8'd0, 8'd0);
        fetch_texel(8'd255, 8'd255);

        // page y bit alone, x offset that vanishes modulo the width, table on row one
        write_config(16'h0010, 16'h0040);
        fetch_texel(8'd200, 8'd0);
        fetch_texel(8'd7, 8'd255);

        // random phases, each with its own setting and every depth in turn
        for (int phase = 0; phase < PHASES; phase++) begin
            page = tpcf_pkg::WORD_W'($urandom());
            page[8:7] = 2'(phase);
            if ($urandom_range(0, 3) != 0) page[11] = 1'b0;
            clut = tpcf_pkg::WORD_W'($urandom());
            if ($urandom_range(0, 3) != 0) clut[15] = 1'b0;
            write_config(page, clut);
            no_idle     = (phase == 4);
            rx_hold_req = (phase == 2);
            phase_start = items_sent;
            paused      = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // odd phases stop halfway until the block has emptied
                if (!paused && phase[0] && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain_block();
                    paused = 1'b1;
                end
                random_transaction();
            end
        end

        drain_block();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tpcf_pkg.sv
rtl/tpcf_ram.sv
rtl/texture_page_clut_fetch.sv
tb/texture_page_clut_fetch_checker.sv
tb/tb_texture_page_clut_fetch.sv
